/* rtl/stie_pkg.sv */
package stie_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOT_ASC = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOT_RDY = 3'd3;
  localparam logic [2:0] ST_DIV0    = 3'd4;

  // operand select carried in the command's err field during a multiply
  localparam logic [2:0] SEL_NONE    = 3'd0;
  localparam logic [2:0] SEL_TAIL_LO = 3'd5;
  localparam logic [2:0] SEL_TAIL_HI = 3'd6;

  localparam logic [1:0] REG_WP_LO = 2'd0;
  localparam logic [1:0] REG_G_LO  = 2'd1;
  localparam logic [1:0] REG_WP_HI = 2'd2;
  localparam logic [1:0] REG_G_HI  = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_RD_LAST, CMD_LOAD, CMD_RD_FIRST, CMD_RD_MID,
    CMD_STEP, CMD_RD_BR, CMD_MUL, CMD_DIV_TAIL, CMD_DIV_INT, CMD_DIV, CMD_FIN,
    CMD_ERR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] err;
  } cmd_t;

  typedef struct packed {
    logic          below;
    logic          above;
    logic          searching;
    logic          div_done;
    logic          div0;
    logic          not_asc;
    logic          full;
    logic          not_ready;
    logic          mul_done;
  } sts_t;
endpackage

/* rtl/stie_if.sv */
interface stie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] freq;
  logic signed [31:0] eps_point;
  modport source (output valid, kind, freq, eps_point, input ready);
  modport sink (input valid, kind, freq, eps_point, output ready);
endinterface

interface stie_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] eps_value;
  logic [2:0]  status;
  logic        saturated;
  modport source (output valid, eps_value, status, saturated, input ready);
  modport sink (input valid, eps_value, status, saturated, output ready);
endinterface

/* rtl/sorted_table_interp_with_drude_tails.sv */
// Piecewise-linear table interpolator with Drude tails. One request at a time,
// and a new request is taken only once the previous result has left. Clear
// and unused kinds are answered straight from idle; an append reads the last
// entry, writes if it can and then reports its status. A query first reads
// the table ends; a query that fails its checks ends with an error status.
// Otherwise a tail query runs two multiplies, the divider and a delivery step.
// An inner query runs the bisection (a midpoint read and a step per halving),
// two bracket reads, one multiply, the divider and a delivery step. The table
// memory needs no clearing pass; data from unwritten entries is never used.
module sorted_table_interp_with_drude_tails (
  input  logic        clk,
  input  logic        rst_n,
  stie_in_if.sink     in_ch,
  stie_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import stie_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic res_load;
  logic [31:0] res_val;
  logic [2:0] res_st;
  logic res_sat;
  logic ov_r;
  logic [31:0] oval_r;
  logic [2:0] ost_r;
  logic osat_r;
  logic [31:0] freq_r;
  logic [31:0] eps_r;

  stie_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .kind(in_ch.kind), .sts, .cmd, .res_load, .out_free(!ov_r)
  );

  stie_datapath u_dp (
    .clk, .rst_n, .cmd, .freq(freq_r),
    .eps_point(eps_r), .cfg_we, .cfg_idx, .cfg_data,
    .sts, .res_val, .res_st, .res_sat
  );

  // hold the request fields once accepted
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      freq_r <= in_ch.freq; eps_r <= in_ch.eps_point;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else begin
      if (out_ch.ready) ov_r <= 1'b0;
      if (res_load) begin
        ov_r <= 1'b1; oval_r <= res_val; ost_r <= res_st; osat_r <= res_sat;
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.eps_value = oval_r;
  assign out_ch.status = ost_r;
  assign out_ch.saturated = osat_r;
endmodule

/* rtl/stie_datapath.sv */
module stie_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  stie_pkg::cmd_t   cmd,
  input  logic [31:0]      freq,
  input  logic [31:0]      eps_point,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_data,
  output stie_pkg::sts_t   sts,
  output logic [31:0]      res_val,
  output logic [2:0]       res_st,
  output logic             res_sat
);
  import stie_pkg::*;

  logic [31:0] ftab [TABLE_DEPTH];
  logic [31:0] etab [TABLE_DEPTH];
  logic [31:0] frd_r, erd_r;
  logic [31:0] wp_lo_r, g_lo_r, wp_hi_r, g_hi_r;
  logic [CW-1:0] cnt_r;
  logic          inv_r;
  logic [31:0] xi_r, fl_r, el_r, first_r;
  logic [CW-1:0] lo_r, hi_r;
  logic          neg_r, rd_phase_r;
  logic [2:0]  mphase_r;
  logic [127:0] n_r, d_r, q_r, r_r;
  logic [7:0]  dcnt_r;
  logic        busy_r, ddone_r, mdone_r;
  logic [63:0] acc_r;
  logic [31:0] ma_r, mb_r;
  logic [31:0] ma2_r;
  logic        cy_r;
  logic        mode_tail_r;

  logic [AW-1:0] raddr;
  logic [CW-1:0] mid;
  logic [CW-1:0] cnt_m1;
  logic [128:0]  trial;

  assign cnt_m1 = cnt_r - CW'(1);
  assign mid = CW'((lo_r + hi_r) >> 1);
  assign trial = {r_r, n_r[127]} - {1'b0, d_r};

  always_comb begin
    case (cmd.op)
      CMD_RD_LAST:  raddr = cnt_m1[AW-1:0];
      CMD_RD_FIRST: raddr = '0;
      CMD_RD_MID:   raddr = mid[AW-1:0];
      CMD_RD_BR:    raddr = rd_phase_r ? hi_r[AW-1:0] : lo_r[AW-1:0];
      default:      raddr = cnt_m1[AW-1:0];
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD && !sts.full && !sts.not_asc) begin
      ftab[cnt_r[AW-1:0]] <= freq;
      etab[cnt_r[AW-1:0]] <= eps_point;
    end
    frd_r <= ftab[raddr];
    erd_r <= etab[raddr];
  end

  assign sts.full = (cnt_r == CW'(TABLE_DEPTH));
  assign sts.not_asc = (cnt_r != '0) && (freq <= frd_r);
  assign sts.not_ready = inv_r || (cnt_r < CW'(2));
  assign sts.below = freq < first_r;
  assign sts.above = freq > frd_r;
  assign sts.searching = (hi_r - lo_r) != CW'(1);
  assign sts.div_done = ddone_r;
  assign sts.div0 = (freq == '0);
  assign sts.mul_done = mdone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_lo_r <= '0; g_lo_r <= '0; wp_hi_r <= '0; g_hi_r <= '0;
      cnt_r <= '0; inv_r <= 1'b0; busy_r <= 1'b0; ddone_r <= 1'b0;
      mdone_r <= 1'b0; mphase_r <= '0; rd_phase_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WP_LO: wp_lo_r <= cfg_data;
          REG_G_LO:  g_lo_r <= cfg_data;
          REG_WP_HI: wp_hi_r <= cfg_data;
          REG_G_HI:  g_hi_r <= cfg_data;
          default:   wp_lo_r <= wp_lo_r;
        endcase
      end
      ddone_r <= 1'b0;
      mdone_r <= 1'b0;
      case (cmd.op)
        CMD_CLEAR: begin
          cnt_r <= '0; inv_r <= 1'b0;
        end
        CMD_RD_LAST: begin
          // during a query, the first entry is in frd_r when the last one is requested
          first_r <= frd_r;
        end
        CMD_LOAD: begin
          if (sts.full || sts.not_asc) inv_r <= 1'b1;
          else cnt_r <= cnt_r + CW'(1);
        end
        CMD_RD_FIRST: begin
          lo_r <= '0; hi_r <= cnt_m1; xi_r <= freq;
          rd_phase_r <= 1'b0; mphase_r <= '0;
        end
        CMD_RD_MID: ;
        CMD_STEP: begin
          if (frd_r > xi_r) hi_r <= mid;
          else lo_r <= mid;
          rd_phase_r <= 1'b0;
        end
        CMD_RD_BR: begin
          rd_phase_r <= 1'b1;
          if (rd_phase_r) begin
            // second read phase: lower entry data is here
            fl_r <= frd_r; el_r <= erd_r;
          end
          mphase_r <= '0;
        end
        CMD_MUL: begin
          // two 32x16 partials per product, operands set in phase zero
          mphase_r <= mphase_r + 3'd1;
          case (mphase_r)
            3'd0: begin
              if (cmd.err == SEL_TAIL_HI) begin
                ma_r <= wp_hi_r; mb_r <= wp_hi_r;
                ma2_r <= g_hi_r;
              end else if (cmd.err == SEL_TAIL_LO) begin
                ma_r <= wp_lo_r; mb_r <= wp_lo_r;
                ma2_r <= g_lo_r;
              end else begin
                ma_r <= xi_r - fl_r;
                neg_r <= $signed(erd_r) < $signed(el_r);
                mb_r <= ($signed(erd_r) < $signed(el_r)) ? el_r - erd_r : erd_r - el_r;
                d_r <= {96'd0, frd_r - fl_r};
                ma2_r <= '0;
              end
              acc_r <= '0;
            end
            3'd1: acc_r <= {32'd0, ma_r} * {48'd0, mb_r[15:0]};
            3'd2: acc_r <= acc_r + (({32'd0, ma_r} * {48'd0, mb_r[31:16]}) << 16);
            3'd3: begin
              if (mode_tail_r) begin
                n_r <= {48'd0, acc_r, 16'd0};
                mb_r <= xi_r + ma2_r;
                ma_r <= xi_r;
                cy_r <= xi_r + ma2_r < xi_r;
                acc_r <= '0;
              end else begin
                n_r <= {64'd0, acc_r};
                mdone_r <= 1'b1;
              end
            end
            3'd4: acc_r <= {32'd0, ma_r} * {48'd0, mb_r[15:0]};
            3'd5: acc_r <= acc_r + (({32'd0, ma_r} * {48'd0, mb_r[31:16]}) << 16);
            default: begin
              // add back the carry of xi + g as xi << 32
              d_r <= {64'd0, acc_r} + (cy_r ? {64'd0, ma_r, 32'd0} : 128'd0);
              mdone_r <= 1'b1;
            end
          endcase
        end
        CMD_DIV: begin
          if (!busy_r && !ddone_r) begin
            busy_r <= 1'b1; dcnt_r <= 8'd128; r_r <= '0; q_r <= '0;
          end else if (dcnt_r != 8'd0) begin
            if (!trial[128]) r_r <= trial[127:0];
            else r_r <= {r_r[126:0], n_r[127]};
            q_r <= {q_r[126:0], !trial[128]};
            n_r <= {n_r[126:0], 1'b0};
            dcnt_r <= dcnt_r - 8'd1;
            if (dcnt_r == 8'd1) begin
              busy_r <= 1'b0; ddone_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // latch whether this multiply serves a tail
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MUL && mphase_r == 3'd0)
      mode_tail_r <= (cmd.err == SEL_TAIL_LO) || (cmd.err == SEL_TAIL_HI);
  end

  // result formatting
  always_comb begin
    res_val = '0; res_st = cmd.err; res_sat = 1'b0;
    if (cmd.op == CMD_FIN) begin
      res_st = ST_OK;
      if (mode_tail_r) begin
        if (q_r[127:31] != '0) begin
          res_val = 32'h7FFF_FFFF; res_sat = 1'b1;
        end else res_val = q_r[31:0];
      end else begin
        res_val = neg_r ? el_r - q_r[31:0] : el_r + q_r[31:0];
      end
    end else if (cmd.op == CMD_ERR) begin
      res_st = cmd.err;
    end else res_st = ST_OK;
  end
endmodule

/* rtl/stie_ctrl.sv */
module stie_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      kind,
  input  stie_pkg::sts_t  sts,
  output stie_pkg::cmd_t  cmd,
  output logic            res_load,
  input  logic            out_free
);
  import stie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LRD, S_LD, S_QRD0, S_QRD1, S_QCHK, S_MRD, S_MSTEP,
    S_BR0, S_BR1, S_MUL, S_DIV, S_FIN, S_ERR, S_DONE
  } state_t;

  state_t state_r;
  logic [2:0] err_r;
  logic [2:0] sel_r;

  assign in_ready = (state_r == S_IDLE) && out_free;

  always_comb begin
    cmd.op = CMD_NONE; cmd.err = sel_r; res_load = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && out_free) begin
        case (kind)
          KIND_CLEAR: begin cmd.op = CMD_CLEAR; res_load = 1'b1; cmd.err = ST_OK; end
          KIND_LOAD, KIND_QUERY: cmd.op = CMD_RD_LAST;
          default: begin res_load = 1'b1; cmd.err = ST_OK; end
        endcase
      end
      S_LRD:  cmd.op = CMD_RD_LAST;
      S_LD:   cmd.op = CMD_LOAD;
      S_QRD0: cmd.op = CMD_RD_FIRST;
      S_QRD1: cmd.op = CMD_RD_LAST;
      S_MRD:  cmd.op = CMD_RD_MID;
      S_MSTEP: cmd.op = CMD_STEP;
      S_BR0, S_BR1: cmd.op = CMD_RD_BR;
      S_MUL:  cmd.op = CMD_MUL;
      S_DIV:  cmd.op = CMD_DIV;
      S_FIN:  begin cmd.op = CMD_FIN; res_load = 1'b1; end
      S_ERR:  begin cmd.op = CMD_ERR; cmd.err = err_r; res_load = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; err_r <= ST_OK; sel_r <= SEL_NONE;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid && out_free) begin
          if (kind == KIND_LOAD) state_r <= S_LRD;
          else if (kind == KIND_QUERY) state_r <= S_QRD0;
        end
        S_LRD: state_r <= S_LD;
        S_LD: begin
          if (sts.full) begin err_r <= ST_FULL; state_r <= S_ERR; end
          else if (sts.not_asc) begin err_r <= ST_NOT_ASC; state_r <= S_ERR; end
          else begin err_r <= ST_OK; state_r <= S_ERR; end
        end
        S_QRD0: state_r <= S_QRD1;
        S_QRD1: state_r <= S_QCHK;
        S_QCHK: begin
          if (sts.not_ready) begin
            sel_r <= SEL_NONE; err_r <= ST_NOT_RDY; state_r <= S_ERR;
          end else if (sts.below) begin
            if (sts.div0) begin
              sel_r <= SEL_NONE; err_r <= ST_DIV0; state_r <= S_ERR;
            end else begin sel_r <= SEL_TAIL_LO; state_r <= S_MUL; end
          end else if (sts.above) begin sel_r <= SEL_TAIL_HI; state_r <= S_MUL; end
          else begin
            sel_r <= SEL_NONE;
            state_r <= sts.searching ? S_MRD : S_BR0;
          end
        end
        // leave the search once the bracket is one entry wide
        S_MRD: state_r <= sts.searching ? S_MSTEP : S_BR0;
        S_MSTEP: state_r <= S_MRD;
        S_BR0: state_r <= S_BR1;
        S_BR1: state_r <= S_MUL;
        S_MUL: if (sts.mul_done) state_r <= S_DIV;
        S_DIV: if (sts.div_done) state_r <= S_FIN;
        S_FIN, S_ERR: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
